FILE: rtl/core/lps_pkg.sv
`default_nettype none

package lps_pkg;

   localparam int LedCountDefault = 64;
   localparam int PixelIndexWidth = 8;
   localparam int LevelWidth = 8;
   localparam int ColourWidth = 3 * LevelWidth;

   localparam logic [7:0] HueMax = 8'd251;
   localparam logic [7:0] SectorSpan = 8'd42;
   localparam logic [7:0] Full = 8'd255;

   // pos * 255 / 41 as (x * PosRecip) >> PosShift, exact for x <= 41 * 255
   localparam logic [14:0] PosRecip = 15'd25576;
   localparam int PosShift = 20;

   typedef enum logic [1:0] {
      ACT_WRITE_RGB = 2'd0,
      ACT_WRITE_HSV = 2'd1,
      ACT_READ      = 2'd2,
      ACT_CLEAR     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_RESP,
      ST_HSV_POS,
      ST_HSV_MUL1,
      ST_HSV_DIV,
      ST_HSV_MUL2,
      ST_HSV_WRITE
   } state_type;

   typedef struct packed {
      logic write_rgb;
      logic capture_hsv;
      logic write_hsv;
      logic read;
      logic clear_all;
   } ctrl_cmd_type;

   // truncating x / 255 for x <= 65025
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lps_ctrl.sv
`default_nettype none

module lps_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            req_action,
   output logic                       busy,
   output logic                       rsp_strobe,
   output lps_pkg::ctrl_cmd_type      cmd
);

   lps_pkg::state_type state_ff, state_in;
   logic accept;

   assign accept = start && (state_ff == lps_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         lps_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (lps_pkg::action_type'(req_action))
                  lps_pkg::ACT_WRITE_RGB: cmd.write_rgb = 1'b1;
                  lps_pkg::ACT_WRITE_HSV: begin
                     cmd.capture_hsv = 1'b1;
                     state_in = lps_pkg::ST_HSV_POS;
                  end
                  lps_pkg::ACT_READ: begin
                     cmd.read = 1'b1;
                     state_in = lps_pkg::ST_READ_RESP;
                  end
                  lps_pkg::ACT_CLEAR: cmd.clear_all = 1'b1;
                  default: state_in = lps_pkg::ST_IDLE;
               endcase
            end
         end
         lps_pkg::ST_READ_RESP: begin
            rsp_strobe = 1'b1;
            state_in = lps_pkg::ST_IDLE;
         end
         lps_pkg::ST_HSV_POS:  state_in = lps_pkg::ST_HSV_MUL1;
         lps_pkg::ST_HSV_MUL1: state_in = lps_pkg::ST_HSV_DIV;
         lps_pkg::ST_HSV_DIV:  state_in = lps_pkg::ST_HSV_MUL2;
         lps_pkg::ST_HSV_MUL2: state_in = lps_pkg::ST_HSV_WRITE;
         lps_pkg::ST_HSV_WRITE: begin
            cmd.write_hsv = 1'b1;
            state_in = lps_pkg::ST_IDLE;
         end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   a_read_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == lps_pkg::ACT_READ) |=> rsp_strobe)
      else $error("read accepted without response beat");

   a_beat_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && (req_action == lps_pkg::ACT_READ)))
      else $error("response beat without read");

   a_hsv_write_timing: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == lps_pkg::ACT_WRITE_HSV) |-> ##5 cmd.write_hsv)
      else $error("hsv write not issued on time");

endmodule

`default_nettype wire

FILE: rtl/core/lps_datapath.sv
`default_nettype none

module lps_datapath #(
   parameter int LED_COUNT = lps_pkg::LedCountDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lps_pkg::ctrl_cmd_type cmd,
   input  wire logic [7:0]           req_pixel_index,
   input  wire logic [7:0]           req_red_in,
   input  wire logic [7:0]           req_green_in,
   input  wire logic [7:0]           req_blue_in,
   input  wire logic [7:0]           req_hue_in,
   input  wire logic [7:0]           req_saturation_in,
   input  wire logic [7:0]           req_brightness_in,
   output logic [7:0]                rsp_red_out,
   output logic [7:0]                rsp_green_out,
   output logic [7:0]                rsp_blue_out,
   output logic                      rsp_found
);

   localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CW = lps_pkg::ColourWidth;

   logic [CW-1:0]        mem [LED_COUNT];
   logic [LED_COUNT-1:0] valid_ff;

   logic            req_in_range;
   logic [IdxW-1:0] req_addr;

   logic [7:0]  hue_c;
   logic [2:0]  sector;
   logic [7:0]  base;
   logic [5:0]  pos_raw;

   logic [2:0]      sector_ff;
   logic [13:0]     x_ff;
   logic [7:0]      sat_ff, val_ff;
   logic [IdxW-1:0] hidx_ff;
   logic            hin_ff;

   logic [28:0] pos_prod;
   logic [7:0]  pos_ff;
   logic [15:0] sp_ff, sq_ff, lp_ff;
   logic [7:0]  fall_t_ff, rise_t_ff, lo_ff;
   logic [15:0] fp_ff, rp_ff;
   logic [7:0]  fall, rise;
   logic [CW-1:0] hsv_rgb;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [CW-1:0]   wr_data;

   logic [CW-1:0] rd_data_ff;
   logic          rd_hit_ff, rd_found_ff;

   assign req_in_range = req_pixel_index < 8'(LED_COUNT);
   assign req_addr = req_pixel_index[IdxW-1:0];

   always_comb begin
      hue_c = (req_hue_in > lps_pkg::HueMax) ? lps_pkg::HueMax : req_hue_in;
      if (hue_c >= 8'd210) begin
         sector = 3'd5; base = 8'd210;
      end else if (hue_c >= 8'd168) begin
         sector = 3'd4; base = 8'd168;
      end else if (hue_c >= 8'd126) begin
         sector = 3'd3; base = 8'd126;
      end else if (hue_c >= 8'd84) begin
         sector = 3'd2; base = 8'd84;
      end else if (hue_c >= lps_pkg::SectorSpan) begin
         sector = 3'd1; base = lps_pkg::SectorSpan;
      end else begin
         sector = 3'd0; base = 8'd0;
      end
      pos_raw = 6'(hue_c - base);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_hsv) begin
         sector_ff <= sector;
         x_ff      <= {pos_raw, 8'd0} - 14'(pos_raw);
         sat_ff    <= req_saturation_in;
         val_ff    <= req_brightness_in;
         hidx_ff   <= req_addr;
         hin_ff    <= req_in_range;
      end
   end

   assign pos_prod = 29'(x_ff) * 29'(lps_pkg::PosRecip);

   // stage registers run freely; the controller times the final write
   always_ff @(posedge clock) begin
      pos_ff    <= pos_prod[lps_pkg::PosShift +: 8];
      sp_ff     <= 16'(sat_ff) * 16'(pos_ff);
      sq_ff     <= 16'(sat_ff) * 16'(lps_pkg::Full - pos_ff);
      lp_ff     <= 16'(val_ff) * 16'(lps_pkg::Full - sat_ff);
      fall_t_ff <= lps_pkg::Full - lps_pkg::div255(sp_ff);
      rise_t_ff <= lps_pkg::Full - lps_pkg::div255(sq_ff);
      lo_ff     <= lps_pkg::div255(lp_ff);
      fp_ff     <= 16'(val_ff) * 16'(fall_t_ff);
      rp_ff     <= 16'(val_ff) * 16'(rise_t_ff);
   end

   assign fall = lps_pkg::div255(fp_ff);
   assign rise = lps_pkg::div255(rp_ff);

   always_comb begin
      case (sector_ff)
         3'd0:    hsv_rgb = {val_ff, rise, lo_ff};
         3'd1:    hsv_rgb = {fall, val_ff, lo_ff};
         3'd2:    hsv_rgb = {lo_ff, val_ff, rise};
         3'd3:    hsv_rgb = {lo_ff, fall, val_ff};
         3'd4:    hsv_rgb = {rise, lo_ff, val_ff};
         default: hsv_rgb = {val_ff, lo_ff, fall};
      endcase
   end

   always_comb begin
      if (cmd.write_hsv) begin
         wr_en   = hin_ff;
         wr_addr = hidx_ff;
         wr_data = hsv_rgb;
      end else begin
         wr_en   = cmd.write_rgb && req_in_range;
         wr_addr = req_addr;
         wr_data = {req_red_in, req_green_in, req_blue_in};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_hit_ff   <= 1'b0;
         rd_found_ff <= 1'b0;
      end else begin
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.read) begin
            rd_found_ff <= req_in_range;
            rd_hit_ff   <= req_in_range && valid_ff[req_addr];
         end
      end
   end

   assign rsp_red_out   = rd_data_ff[23:16] & {8{rd_hit_ff}};
   assign rsp_green_out = rd_data_ff[15:8] & {8{rd_hit_ff}};
   assign rsp_blue_out  = rd_data_ff[7:0] & {8{rd_hit_ff}};
   assign rsp_found     = rd_found_ff;

   a_hit_needs_found: assert property (@(posedge clock) disable iff (reset)
      rd_hit_ff |-> rd_found_ff)
      else $error("read hit outside the strip");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> (valid_ff == '0))
      else $error("store not empty after clear");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_hsv && (cmd.write_rgb || cmd.clear_all || cmd.read)))
      else $error("hsv write clashes with another command");

endmodule

`default_nettype wire

FILE: rtl/core/led_pixel_store_hsv_unit.sv
`default_nettype none

// Colour store for an LED strip of LED_COUNT pixels, with HSV to RGB conversion.
// Input: an item is taken on a rising edge with start high and busy low.
//   req_action selects write RGB, write HSV, read pixel or clear all.
// Output: a read gives one beat, rsp_strobe high for one cycle, in the cycle
//   after acceptance; rsp_found is low and the levels are zero when the index
//   is at or beyond LED_COUNT. Writes and clear give no beat.
// Timing: RGB write and clear keep the controller idle, so start may stay high.
//   A read goes through a registered store read, then the beat.
//   An HSV write holds busy through the converter sequence:
//   sector scale, two multiply / divide-by-255 rounds, then the store write.
// The receiver cannot stall; a beat is lost if not taken in its cycle.
// Reset: synchronous, clears the controller and the per-pixel valid bits,
//   so every pixel reads as zero at once; clear empties the valid bits likewise.
module led_pixel_store_hsv_unit #(
   parameter int LED_COUNT = lps_pkg::LedCountDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_pixel_index,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_blue_in,
   input  wire logic [7:0] req_hue_in,
   input  wire logic [7:0] req_saturation_in,
   input  wire logic [7:0] req_brightness_in,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_red_out,
   output logic [7:0]      rsp_green_out,
   output logic [7:0]      rsp_blue_out,
   output logic            rsp_found
);

   lps_pkg::ctrl_cmd_type cmd;

   lps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   lps_datapath #(
      .LED_COUNT (LED_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_pixel_index   (req_pixel_index),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_hue_in        (req_hue_in),
      .req_saturation_in (req_saturation_in),
      .req_brightness_in (req_brightness_in),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_found         (rsp_found)
   );

endmodule

`default_nettype wire

FILE: tb/led_pixel_store_hsv_unit_test.sv
`timescale 1ns / 1ps

module led_pixel_store_hsv_unit_test;
   import lps_pkg::*;

   localparam int LedCount = LedCountDefault;
   localparam int SectorTop = 41;
   localparam int QuietLimit = 2000;
   localparam int RandomItems = 1525;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       found;
   } read_beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_action;
   logic [7:0] req_pixel_index;
   logic [7:0] req_red_in;
   logic [7:0] req_green_in;
   logic [7:0] req_blue_in;
   logic [7:0] req_hue_in;
   logic [7:0] req_saturation_in;
   logic [7:0] req_brightness_in;
   logic       rsp_strobe;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic       rsp_found;

   logic [23:0]   pixel_mirror [LedCount];
   read_beat_type pending_reads [$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   bit            gaps_on = 1'b1;

   led_pixel_store_hsv_unit #(.LED_COUNT(LedCount)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_pixel_index(req_pixel_index),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .req_hue_in(req_hue_in),
      .req_saturation_in(req_saturation_in),
      .req_brightness_in(req_brightness_in),
      .rsp_strobe(rsp_strobe),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_found(rsp_found)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [23:0] hsv_to_levels(input logic [7:0] hue, sat, val);
      int unsigned h, s, v, pos, sector, lo, fall, rise;
      s = sat;
      v = val;
      if (s == 0) return {val, val, val};
      h = (hue > HueMax) ? int'(HueMax) : int'(hue);
      pos = (h % int'(SectorSpan)) * 255 / SectorTop;
      sector = h / int'(SectorSpan);
      lo = v * (255 - s) / 255;
      fall = v * (255 - (s * pos) / 255) / 255;
      rise = v * (255 - (s * (255 - pos)) / 255) / 255;
      case (sector)
         0: return {val, rise[7:0], lo[7:0]};
         1: return {fall[7:0], val, lo[7:0]};
         2: return {lo[7:0], val, rise[7:0]};
         3: return {lo[7:0], fall[7:0], val};
         4: return {rise[7:0], lo[7:0], val};
         default: return {val, lo[7:0], fall[7:0]};
      endcase
   endfunction

   task automatic apply_to_mirror(input action_type act, input logic [7:0] idx,
                                  input logic [7:0] r, g, b, h, s, v);
      read_beat_type beat;
      case (act)
         ACT_WRITE_RGB: if (idx < LedCount) pixel_mirror[idx] = {r, g, b};
         ACT_WRITE_HSV: if (idx < LedCount) pixel_mirror[idx] = hsv_to_levels(h, s, v);
         ACT_READ: begin
            if (idx < LedCount) begin
               {beat.red, beat.green, beat.blue} = pixel_mirror[idx];
               beat.found = 1'b1;
            end else begin
               beat = '{8'd0, 8'd0, 8'd0, 1'b0};
            end
            pending_reads.push_back(beat);
         end
         default: foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
      endcase
   endtask

   task automatic send_item(input action_type act, input logic [7:0] idx,
                            input logic [7:0] r = 0, g = 0, b = 0,
                            input logic [7:0] h = 0, s = 0, v = 0);
      @(negedge clock);
      start <= 1'b1;
      req_action <= act;
      req_pixel_index <= idx;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      req_hue_in <= h;
      req_saturation_in <= s;
      req_brightness_in <= v;
      do @(posedge clock); while (busy);
      apply_to_mirror(act, idx, r, g, b, h, s, v);
      if (gaps_on && $urandom_range(99) < 12) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   task automatic test_reset_contents();
      send_item(ACT_READ, 8'd0);
      send_item(ACT_READ, 8'(LedCount - 1));
      send_item(ACT_READ, 8'(LedCount));
   endtask

   task automatic test_rgb_extremes();
      send_item(ACT_WRITE_RGB, 8'd0, 8'hff, 8'hff, 8'hff);
      send_item(ACT_WRITE_RGB, 8'(LedCount - 1), 8'haa, 8'h55, 8'h0f);
      send_item(ACT_WRITE_RGB, 8'(LedCount), 8'h01, 8'h02, 8'h03);
      send_item(ACT_WRITE_RGB, 8'hff, 8'hf0, 8'h3c, 8'hc3);
      send_item(ACT_READ, 8'd0);
      send_item(ACT_READ, 8'(LedCount - 1));
      send_item(ACT_READ, 8'hff);
   endtask

   task automatic test_hsv_corners();
      // grey, sector edges, the hue clamp, zero brightness, out of range
      send_item(ACT_WRITE_HSV, 8'd1, 8'h12, 8'h34, 8'h56, 8'd17, 8'd0, 8'd200);
      send_item(ACT_WRITE_HSV, 8'd2, 8'h00, 8'h00, 8'h00, 8'd0, 8'd255, 8'd255);
      send_item(ACT_WRITE_HSV, 8'd3, 8'h00, 8'h00, 8'h00, 8'd41, 8'd128, 8'd200);
      send_item(ACT_WRITE_HSV, 8'd4, 8'h00, 8'h00, 8'h00, 8'd84, 8'd255, 8'd255);
      send_item(ACT_WRITE_HSV, 8'd5, 8'h00, 8'h00, 8'h00, 8'd210, 8'd255, 8'd0);
      send_item(ACT_WRITE_HSV, 8'd6, 8'h00, 8'h00, 8'h00, 8'd255, 8'd1, 8'd255);
      send_item(ACT_WRITE_HSV, 8'(LedCount), 8'h00, 8'h00, 8'h00, 8'd100, 8'd200, 8'd150);
      for (int i = 1; i <= 6; i++) send_item(ACT_READ, 8'(i));
   endtask

   task automatic test_clear();
      send_item(ACT_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      send_item(ACT_READ, 8'd0);
   endtask

   task automatic test_random_traffic();
      action_type act;
      logic [7:0] idx, r, g, b, h, s, v;
      int         pick;
      int         sent;
      sent = 0;
      while (sent < RandomItems) begin
         gaps_on = !(sent >= 600 && sent < 900);
         pick = $urandom_range(99);
         if (pick < 30) act = ACT_WRITE_RGB;
         else if (pick < 60) act = ACT_WRITE_HSV;
         else if (pick < 98) act = ACT_READ;
         else act = ACT_CLEAR;
         idx = ($urandom_range(99) < 85) ? 8'($urandom_range(LedCount - 1))
                                         : 8'($urandom_range(255, LedCount));
         r = 8'($urandom);
         g = 8'($urandom);
         b = 8'($urandom);
         h = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 240)) : 8'($urandom);
         pick = $urandom_range(99);
         s = (pick < 10) ? 8'd0 : (pick < 15) ? 8'd255 : 8'($urandom);
         pick = $urandom_range(99);
         v = (pick < 5) ? 8'd0 : (pick < 10) ? 8'd255 : 8'($urandom);
         send_item(act, idx, r, g, b, h, s, v);
         sent++;
         if ((act == ACT_WRITE_RGB || act == ACT_WRITE_HSV) && $urandom_range(99) < 30) begin
            send_item(ACT_READ, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
         end
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      read_beat_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reads.size() == 0) begin
            $error("rsp beat with no read outstanding");
            error_count++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_red_out !== want.red) begin
               $error("red_out: expected %0d, got %0d", want.red, rsp_red_out);
               error_count++;
            end
            if (rsp_green_out !== want.green) begin
               $error("green_out: expected %0d, got %0d", want.green, rsp_green_out);
               error_count++;
            end
            if (rsp_blue_out !== want.blue) begin
               $error("blue_out: expected %0d, got %0d", want.blue, rsp_blue_out);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("led_pixel_store_hsv_unit_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_READ;
      req_pixel_index = '0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_hue_in = '0;
      req_saturation_in = '0;
      req_brightness_in = '0;
      foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_rgb_extremes();
      test_hsv_corners();
      test_clear();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("led_pixel_store_hsv_unit_test: done, clean");
      end else begin
         $display("led_pixel_store_hsv_unit_test: done, errors");
      end
      $finish;
   end

endmodule
